// ===== hw/rtl/xlsfe_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// xlsfe_pkg
// Shared types and constants for the x86 lazy status flag evaluator: command
// codes, width codes, fill modes, EFLAGS bit positions and the operation
// record that travels from the input register to the flag logic.
// ============================================================================
package xlsfe_pkg;

    // Operation kinds of the recorded ALU instruction.
    localparam logic [3:0] CMD_NONE  = 4'd0;
    localparam logic [3:0] CMD_ADD   = 4'd1;
    localparam logic [3:0] CMD_ADC   = 4'd2;
    localparam logic [3:0] CMD_SUB   = 4'd3;
    localparam logic [3:0] CMD_SBB   = 4'd4;
    localparam logic [3:0] CMD_LOGIC = 4'd5;
    localparam logic [3:0] CMD_INC   = 4'd6;
    localparam logic [3:0] CMD_DEC   = 4'd7;
    localparam logic [3:0] CMD_NEG   = 4'd8;
    localparam logic [3:0] CMD_SHL   = 4'd9;
    localparam logic [3:0] CMD_SHR   = 4'd10;
    localparam logic [3:0] CMD_SAR   = 4'd11;
    localparam logic [3:0] CMD_DSHL  = 4'd12;
    localparam logic [3:0] CMD_DSHR  = 4'd13;

    // Operand width codes; the unused code behaves as 32 bits.
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;

    // Fill modes: flags that are left cleared for the caller.
    localparam logic [2:0] FILL_NO_CF    = 3'd1;
    localparam logic [2:0] FILL_NO_ZF    = 3'd2;
    localparam logic [2:0] FILL_NO_OF    = 3'd3;
    localparam logic [2:0] FILL_NO_CF_OF = 3'd4;

    // EFLAGS bit positions of the arithmetic flags.
    localparam int unsigned FLAG_CF_BIT = 0;
    localparam int unsigned FLAG_PF_BIT = 2;
    localparam int unsigned FLAG_AF_BIT = 4;
    localparam int unsigned FLAG_ZF_BIT = 6;
    localparam int unsigned FLAG_SF_BIT = 7;
    localparam int unsigned FLAG_OF_BIT = 11;
    localparam logic [31:0] ARITH_MASK  = 32'h0000_08d5;

    // One recorded ALU operation.
    typedef struct packed {
        logic [3:0]  command;
        logic [1:0]  width_code;
        logic [2:0]  fill_mode;
        logic [31:0] dest_value;
        logic [31:0] source_value;
        logic [15:0] second_dest;
        logic [31:0] result_value;
        logic        carry_in;
        logic [31:0] old_flags;
    } t_op_rec;

endpackage

// ===== hw/rtl/xlsfe_flag_calc.sv =====
`timescale 1ns / 1ps
// ============================================================================
// xlsfe_flag_calc
// Combinational flag logic: from one operation record, recomputes CF, PF, AF,
// ZF, SF and OF of the flags word and keeps every other bit; kind none and the
// unused command codes return the old flags word unchanged.
module xlsfe_flag_calc (
    input  xlsfe_pkg::t_op_rec i_op,
    output logic [31:0]        o_new_flags
);

    logic [31:0] mask;
    logic [31:0] msb_val;
    logic [7:0]  width_bits;
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] r;
    logic        d_msb;
    logic        s_msb;
    logic        r_msb;
    logic [7:0]  cnt;
    logic [4:0]  cnt5;
    logic        cnt_in_w;
    logic        cnt_in_32;
    logic [7:0]  shl_idx;
    logic [7:0]  dshl_idx;
    logic [7:0]  cnt_m1;
    logic [4:0]  sar_idx;
    logic [31:0] sext_d;
    logic        is_none;
    logic        cf;
    logic        af;
    logic        of;
    logic        zf;
    logic        pf;
    logic        cf_keep;
    logic        of_keep;
    logic [31:0] flags;

    // Width selection: mask, top-bit value and width in bits.
    always_comb begin
        unique case (i_op.width_code)
            xlsfe_pkg::WIDTH_8: begin
                mask       = 32'h0000_00ff;
                msb_val    = 32'h0000_0080;
                width_bits = 8'd8;
            end
            xlsfe_pkg::WIDTH_16: begin
                mask       = 32'h0000_ffff;
                msb_val    = 32'h0000_8000;
                width_bits = 8'd16;
            end
            default: begin
                mask       = 32'hffff_ffff;
                msb_val    = 32'h8000_0000;
                width_bits = 8'd32;
            end
        endcase
    end

    // Operands at the operand width and their sign bits.
    assign d      = i_op.dest_value & mask;
    assign s      = i_op.source_value & mask;
    assign r      = i_op.result_value & mask;
    assign d_msb  = |(d & msb_val);
    assign s_msb  = |(s & msb_val);
    assign r_msb  = |(r & msb_val);
    assign sext_d = d_msb ? (d | ~mask) : d;

    // Shift count decode and bit positions that the shifted-out bit comes from.
    assign cnt       = i_op.source_value[7:0];
    assign cnt5      = i_op.source_value[4:0];
    assign cnt_in_w  = (cnt != 8'd0) && (cnt <= width_bits);
    assign cnt_in_32 = (cnt != 8'd0) && (cnt <= 8'd32);
    assign shl_idx   = width_bits - cnt;
    assign dshl_idx  = 8'd32 - cnt;
    assign cnt_m1    = cnt - 8'd1;
    assign sar_idx   = (cnt > 8'd32) ? 5'd31 : cnt_m1[4:0];

    assign is_none = (i_op.command == xlsfe_pkg::CMD_NONE) ||
                     (i_op.command > xlsfe_pkg::CMD_DSHR);

    // Carry, adjust and overflow by operation kind.
    always_comb begin
        cf = 1'b0;
        af = 1'b0;
        of = 1'b0;
        unique case (i_op.command)
            xlsfe_pkg::CMD_ADD, xlsfe_pkg::CMD_ADC: begin
                cf = (r < d) ||
                     ((i_op.command == xlsfe_pkg::CMD_ADC) && i_op.carry_in && (r == d));
                of = ~(d_msb ^ s_msb) & (r_msb ^ s_msb);
                af = d[4] ^ s[4] ^ r[4];
            end
            xlsfe_pkg::CMD_SUB, xlsfe_pkg::CMD_SBB: begin
                if (i_op.command == xlsfe_pkg::CMD_SUB) begin
                    cf = d < s;
                end else begin
                    cf = (d < r) || (i_op.carry_in && (s == mask));
                end
                of = (d_msb ^ s_msb) & (d_msb ^ r_msb);
                af = d[4] ^ s[4] ^ r[4];
            end
            xlsfe_pkg::CMD_LOGIC: begin
                cf = 1'b0;
            end
            xlsfe_pkg::CMD_INC: begin
                cf = i_op.carry_in;
                of = r == msb_val;
                af = r[3:0] == 4'h0;
            end
            xlsfe_pkg::CMD_DEC: begin
                cf = i_op.carry_in;
                of = r == (msb_val - 32'd1);
                af = r[3:0] == 4'hf;
            end
            xlsfe_pkg::CMD_NEG: begin
                cf = d != 32'd0;
                of = d == msb_val;
                af = d[3:0] != 4'h0;
            end
            xlsfe_pkg::CMD_SHL, xlsfe_pkg::CMD_DSHL: begin
                if (cnt_in_w) begin
                    cf = d[shl_idx[4:0]];
                end else if ((i_op.command == xlsfe_pkg::CMD_DSHL) &&
                             (width_bits == 8'd16) && cnt_in_32) begin
                    cf = i_op.second_dest[dshl_idx[3:0]];
                end
                of = r_msb ^ d_msb;
                af = (i_op.command == xlsfe_pkg::CMD_SHL) && (cnt5 != 5'd0);
            end
            xlsfe_pkg::CMD_SHR: begin
                if (cnt_in_w) begin
                    cf = d[cnt_m1[4:0]];
                end
                of = (cnt5 == 5'd1) && d_msb;
                af = cnt5 != 5'd0;
            end
            xlsfe_pkg::CMD_SAR: begin
                if (cnt != 8'd0) begin
                    cf = sext_d[sar_idx];
                end
                af = cnt5 != 5'd0;
            end
            xlsfe_pkg::CMD_DSHR: begin
                if (cnt_in_32) begin
                    cf = i_op.dest_value[cnt_m1[4:0]];
                end
                of = r_msb ^ d_msb;
            end
            default: begin
                cf = 1'b0;
            end
        endcase
    end

    // Result flags and fill mode masking.
    assign pf      = ~^r[7:0];
    assign zf      = (r == 32'd0) && (i_op.fill_mode != xlsfe_pkg::FILL_NO_ZF);
    assign cf_keep = cf && (i_op.fill_mode != xlsfe_pkg::FILL_NO_CF) &&
                     (i_op.fill_mode != xlsfe_pkg::FILL_NO_CF_OF);
    assign of_keep = of && (i_op.fill_mode != xlsfe_pkg::FILL_NO_OF) &&
                     (i_op.fill_mode != xlsfe_pkg::FILL_NO_CF_OF);

    // Merge the new flags into the kept bits of the old word.
    always_comb begin
        flags                          = i_op.old_flags & ~xlsfe_pkg::ARITH_MASK;
        flags[xlsfe_pkg::FLAG_CF_BIT]  = cf_keep;
        flags[xlsfe_pkg::FLAG_PF_BIT]  = pf;
        flags[xlsfe_pkg::FLAG_AF_BIT]  = af;
        flags[xlsfe_pkg::FLAG_ZF_BIT]  = zf;
        flags[xlsfe_pkg::FLAG_SF_BIT]  = r_msb;
        flags[xlsfe_pkg::FLAG_OF_BIT]  = of_keep;
    end

    assign o_new_flags = is_none ? i_op.old_flags : flags;

endmodule

// ===== hw/rtl/x86_lazy_status_flag_evaluator_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// x86_lazy_status_flag_evaluator_unit
// Evaluates the six arithmetic EFLAGS bits from the record of the last x86
// ALU operation, with an input register, single-pass flag logic and a
// result register.
// ============================================================================
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------
//  in      | into unit | i_in_valid / o_in_stall | i_command ... i_old_flags
//  out     | from unit | o_out_valid / i_out_stall | o_new_flags
//
//  A beat is accepted every cycle unless the input stalls; a beat passes the
//  input register, the flag logic and the result register in that order.
//  Reset clears both valid bits only; payload registers are not reset. A
//  stall at the output holds the result register, and the input stalls only
//  when both registers hold beats and the output is stalled.
//
module x86_lazy_status_flag_evaluator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_command,
    input  logic [1:0]  i_width_code,
    input  logic [2:0]  i_fill_mode,
    input  logic [31:0] i_dest_value,
    input  logic [31:0] i_source_value,
    input  logic [15:0] i_second_dest,
    input  logic [31:0] i_result_value,
    input  logic        i_carry_in,
    input  logic [31:0] i_old_flags,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_new_flags
);

    xlsfe_pkg::t_op_rec r_op;
    xlsfe_pkg::t_op_rec n_op;
    logic               r_op_valid;
    logic               n_op_valid;
    logic [31:0]        r_flags;
    logic [31:0]        n_flags;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               out_free;
    logic               op_free;
    logic               in_take;
    logic [31:0]        calc_flags;

    // Stage advance: each register moves on when the one after it frees up.
    assign out_free = !r_out_valid || !i_out_stall;
    assign op_free  = !r_op_valid || out_free;
    assign in_take  = i_in_valid && op_free;

    // Input register next values.
    always_comb begin
        n_op       = r_op;
        n_op_valid = r_op_valid;
        if (op_free) begin
            n_op_valid = i_in_valid;
        end
        if (in_take) begin
            n_op.command      = i_command;
            n_op.width_code   = i_width_code;
            n_op.fill_mode    = i_fill_mode;
            n_op.dest_value   = i_dest_value;
            n_op.source_value = i_source_value;
            n_op.second_dest  = i_second_dest;
            n_op.result_value = i_result_value;
            n_op.carry_in     = i_carry_in;
            n_op.old_flags    = i_old_flags;
        end
    end

    // Flag evaluation between the two registers.
    xlsfe_flag_calc u_flag_calc (
        .i_op        (r_op),
        .o_new_flags (calc_flags)
    );

    // Result register next values.
    always_comb begin
        n_flags     = r_flags;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_op_valid;
            if (r_op_valid) begin
                n_flags = calc_flags;
            end
        end
    end

    // Valid bits, with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_op_valid  <= n_op_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_flags <= n_flags;
    end

    assign o_in_stall  = !op_free;
    assign o_out_valid = r_out_valid;
    assign o_new_flags = r_flags;

    // A held input beat moves into a free result register on the next edge.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op_valid && out_free) |=> r_out_valid)
        else $error("input beat did not reach the result register");

    // The input stalls only when both registers are full and the output stalls.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_op_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    // Non-arithmetic bits of the flags word always pass through.
    a_keep_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op_valid |->
            ((calc_flags & ~xlsfe_pkg::ARITH_MASK) ==
             (r_op.old_flags & ~xlsfe_pkg::ARITH_MASK)))
        else $error("non-arithmetic flag bits changed");

    // Kind none returns the old flags word unchanged.
    a_none_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_op_valid && (r_op.command == xlsfe_pkg::CMD_NONE)) |->
            (calc_flags == r_op.old_flags))
        else $error("kind none altered the flags word");

    // A stalled result is not overwritten.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_flags)))
        else $error("stalled result changed");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the x86 lazy status flag evaluator. A queue of
// operation records, first hand-picked corner cases and then random records
// with mostly consistent results, is played through the input channel under
// random idle bursts on both sides. Each accepted record is run through a
// local flag predictor, and the flags words that come out are compared in
// order against those predictions.
// ============================================================================
module testbench;

    // Codes that the package leaves unnamed.
    localparam logic [3:0] CMD_UNUSED_14 = 4'd14;
    localparam logic [3:0] CMD_UNUSED_15 = 4'd15;
    localparam logic [1:0] WIDTH_32      = 2'd2;
    localparam logic [1:0] WIDTH_SPARE   = 2'd3;
    localparam logic [2:0] FILL_ALL      = 3'd0;
    localparam logic [2:0] FILL_SPARE_5  = 3'd5;
    localparam logic [2:0] FILL_SPARE_7  = 3'd7;

    localparam int RANDOM_OPS  = 550;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                o_in_stall;
    xlsfe_pkg::t_op_rec  drive_op = '0;
    logic                o_out_valid;
    logic                out_stall = 1'b0;
    logic [31:0]         o_new_flags;

    xlsfe_pkg::t_op_rec  pending_ops[$];
    logic [31:0]         expected_flags_q[$];
    logic [31:0]         want_flags;
    int                  in_gap_left = 0;
    int                  stall_left = 0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;

    x86_lazy_status_flag_evaluator_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (drive_op.command),
        .i_width_code   (drive_op.width_code),
        .i_fill_mode    (drive_op.fill_mode),
        .i_dest_value   (drive_op.dest_value),
        .i_source_value (drive_op.source_value),
        .i_second_dest  (drive_op.second_dest),
        .i_result_value (drive_op.result_value),
        .i_carry_in     (drive_op.carry_in),
        .i_old_flags    (drive_op.old_flags),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_new_flags    (o_new_flags)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reset is held low at the start of the run and released once.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idling is switched off in stretches and over the tail of the run.
    function automatic bit idling_on();
        return pending_ops.size() >= 60 && ((pending_ops.size() / 40) % 4) != 3;
    endfunction

    // Computes the flags word that one recorded operation must produce.
    function automatic logic [31:0] predict_flags(xlsfe_pkg::t_op_rec op);
        int unsigned w;
        int unsigned k;
        logic [31:0] mask;
        logic [31:0] msb;
        logic [31:0] d;
        logic [31:0] s;
        logic [31:0] r;
        logic [31:0] sd;
        logic [31:0] flags;
        logic [7:0]  cnt;
        logic [4:0]  c5;
        logic        cf;
        logic        af;
        logic        of;

        if (op.command == xlsfe_pkg::CMD_NONE || op.command > xlsfe_pkg::CMD_DSHR) begin
            return op.old_flags;
        end
        case (op.width_code)
            xlsfe_pkg::WIDTH_8: begin
                w = 8; mask = 32'h0000_00ff; msb = 32'h0000_0080;
            end
            xlsfe_pkg::WIDTH_16: begin
                w = 16; mask = 32'h0000_ffff; msb = 32'h0000_8000;
            end
            default: begin
                w = 32; mask = 32'hffff_ffff; msb = 32'h8000_0000;
            end
        endcase
        d   = op.dest_value & mask;
        s   = op.source_value & mask;
        r   = op.result_value & mask;
        cnt = op.source_value[7:0];
        c5  = op.source_value[4:0];
        cf  = 1'b0;
        af  = 1'b0;
        of  = 1'b0;

        case (op.command)
            xlsfe_pkg::CMD_ADD, xlsfe_pkg::CMD_ADC: begin
                cf = (r < d) ||
                     (op.command == xlsfe_pkg::CMD_ADC && op.carry_in && r == d);
                of = |((d ^ s ^ msb) & (r ^ s) & msb);
                af = (d ^ s ^ r) & 32'h10 ? 1'b1 : 1'b0;
            end
            xlsfe_pkg::CMD_SUB, xlsfe_pkg::CMD_SBB: begin
                if (op.command == xlsfe_pkg::CMD_SUB) cf = d < s;
                else cf = (d < r) || (op.carry_in && s == mask);
                of = |((d ^ s) & (d ^ r) & msb);
                af = (d ^ s ^ r) & 32'h10 ? 1'b1 : 1'b0;
            end
            xlsfe_pkg::CMD_INC: begin
                cf = op.carry_in;
                of = r == msb;
                af = r[3:0] == 4'h0;
            end
            xlsfe_pkg::CMD_DEC: begin
                cf = op.carry_in;
                of = r == msb - 1;
                af = r[3:0] == 4'hf;
            end
            xlsfe_pkg::CMD_NEG: begin
                cf = d != 0;
                of = d == msb;
                af = d[3:0] != 4'h0;
            end
            xlsfe_pkg::CMD_SHL, xlsfe_pkg::CMD_DSHL: begin
                // A 16-bit double shift pulls CF from the second word for long counts.
                if (cnt >= 1 && cnt <= w) cf = d[w - cnt];
                else if (op.command == xlsfe_pkg::CMD_DSHL && w == 16 && cnt > 16
                         && cnt <= 32)
                    cf = op.second_dest[32 - cnt];
                of = |((r ^ d) & msb);
                af = op.command == xlsfe_pkg::CMD_SHL && c5 != 0;
            end
            xlsfe_pkg::CMD_SHR: begin
                if (cnt >= 1 && cnt <= w) cf = d[cnt - 1];
                of = c5 == 1 && (d & msb) != 0;
                af = c5 != 0;
            end
            xlsfe_pkg::CMD_SAR: begin
                // Counts past the width keep shifting in the sign bit.
                sd = (d & msb) != 0 ? (d | ~mask) : d;
                if (cnt >= 1) begin
                    k = 32'(cnt) - 32'd1;
                    if (k > 31) k = 31;
                    cf = sd[k];
                end
                af = c5 != 0;
            end
            xlsfe_pkg::CMD_DSHR: begin
                if (cnt >= 1 && cnt <= 32) cf = op.dest_value[cnt - 1];
                of = |((r ^ d) & msb);
            end
            default: begin
            end
        endcase

        flags = op.old_flags & ~xlsfe_pkg::ARITH_MASK;
        flags[xlsfe_pkg::FLAG_AF_BIT] = af;
        flags[xlsfe_pkg::FLAG_ZF_BIT] = r == 0 && op.fill_mode != xlsfe_pkg::FILL_NO_ZF;
        flags[xlsfe_pkg::FLAG_PF_BIT] = ~^r[7:0];
        flags[xlsfe_pkg::FLAG_SF_BIT] = (r & msb) != 0;
        flags[xlsfe_pkg::FLAG_CF_BIT] = cf && op.fill_mode != xlsfe_pkg::FILL_NO_CF
                                        && op.fill_mode != xlsfe_pkg::FILL_NO_CF_OF;
        flags[xlsfe_pkg::FLAG_OF_BIT] = of && op.fill_mode != xlsfe_pkg::FILL_NO_OF
                                        && op.fill_mode != xlsfe_pkg::FILL_NO_CF_OF;
        return flags;
    endfunction

    // Operand values that favor boundaries.
    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            4: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [3:0] cmd, input logic [1:0] wc,
                            input logic [2:0] fm, input logic [31:0] d,
                            input logic [31:0] s, input logic [15:0] d2,
                            input logic [31:0] r, input logic cin,
                            input logic [31:0] old);
        xlsfe_pkg::t_op_rec op;
        op.command = cmd;
        op.width_code = wc;
        op.fill_mode = fm;
        op.dest_value = d;
        op.source_value = s;
        op.second_dest = d2;
        op.result_value = r;
        op.carry_in = cin;
        op.old_flags = old;
        pending_ops.push_back(op);
    endtask

    task automatic log_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] %s: new_flags expected %08h, got %08h", $realtime, what,
                     want, got);
        end
    endtask

    // Stimulus: corner cases first, then random records.
    initial begin : stimulus
        xlsfe_pkg::t_op_rec op;
        int                 bits;
        int                 roll;
        logic [31:0]        msk;
        logic [31:0]        sext;
        logic [31:0]        dv;
        logic [31:0]        sv;
        logic [7:0]         cnt;

        // Pass-through kinds, including the unused command codes.
        queue_op(xlsfe_pkg::CMD_NONE, xlsfe_pkg::WIDTH_8, xlsfe_pkg::FILL_NO_CF_OF, 32'h0,
                 32'h0, 16'h0, 32'h0, 1'b1, 32'hffff_ffff);
        queue_op(CMD_UNUSED_15, WIDTH_32, FILL_ALL, 32'h1, 32'h1, 16'hffff, 32'h0, 1'b0,
                 32'h1234_5678);
        queue_op(CMD_UNUSED_14, xlsfe_pkg::WIDTH_16, xlsfe_pkg::FILL_NO_ZF, 32'h5, 32'h5,
                 16'h0, 32'h0, 1'b1, 32'h0000_0000);
        // Carries, overflows and adjust carries at each width.
        queue_op(xlsfe_pkg::CMD_ADD, xlsfe_pkg::WIDTH_8, FILL_ALL, 32'hff, 32'h01, 16'h0,
                 32'h100, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_ADD, WIDTH_32, FILL_SPARE_7, 32'h7fff_ffff, 32'h1, 16'h0,
                 32'h8000_0000, 1'b0, 32'hffff_f72a);
        queue_op(xlsfe_pkg::CMD_ADC, xlsfe_pkg::WIDTH_16, FILL_ALL, 32'hffff, 32'hffff,
                 16'h0, 32'h1ffff, 1'b1, 32'h0);
        queue_op(xlsfe_pkg::CMD_SUB, WIDTH_32, FILL_ALL, 32'h0, 32'hffff_ffff, 16'h0,
                 32'h1, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_SUB, xlsfe_pkg::WIDTH_8, xlsfe_pkg::FILL_NO_ZF, 32'h42,
                 32'h42, 16'h0, 32'h0, 1'b0, 32'hffff_ffff);
        queue_op(xlsfe_pkg::CMD_SBB, xlsfe_pkg::WIDTH_8, xlsfe_pkg::FILL_NO_OF, 32'h12,
                 32'hff, 16'h0, 32'h12, 1'b1, 32'h0);
        queue_op(xlsfe_pkg::CMD_LOGIC, WIDTH_SPARE, FILL_ALL, 32'hffff_ffff, 32'h0, 16'h0,
                 32'h0, 1'b1, 32'hffff_ffff);
        queue_op(xlsfe_pkg::CMD_INC, xlsfe_pkg::WIDTH_16, xlsfe_pkg::FILL_NO_CF, 32'h7fff,
                 32'h0, 16'h0, 32'h8000, 1'b1, 32'h0);
        queue_op(xlsfe_pkg::CMD_DEC, xlsfe_pkg::WIDTH_8, FILL_ALL, 32'h80, 32'h0, 16'h0,
                 32'h7f, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_NEG, WIDTH_32, FILL_ALL, 32'h8000_0000, 32'h0, 16'h0,
                 32'h8000_0000, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_NEG, xlsfe_pkg::WIDTH_8, FILL_ALL, 32'h0, 32'h0, 16'h0,
                 32'h0, 1'b1, 32'h0);
        // Shifts: zero counts, full-width counts and counts out of range.
        queue_op(xlsfe_pkg::CMD_SHL, xlsfe_pkg::WIDTH_8, FILL_ALL, 32'hff, 32'h100, 16'h0,
                 32'hff, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_SHL, WIDTH_32, FILL_ALL, 32'h1, 32'h20, 16'h0, 32'h0, 1'b0,
                 32'h0);
        queue_op(xlsfe_pkg::CMD_SHL, xlsfe_pkg::WIDTH_16, FILL_ALL, 32'hffff, 32'h28,
                 16'h0, 32'h0, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_SHR, xlsfe_pkg::WIDTH_8, FILL_ALL, 32'h81, 32'h1, 16'h0,
                 32'h40, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_SHR, WIDTH_32, FILL_ALL, 32'hffff_ffff, 32'h21, 16'h0,
                 32'h0, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_SAR, xlsfe_pkg::WIDTH_8, FILL_ALL, 32'h80, 32'hc8, 16'h0,
                 32'hff, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_SAR, xlsfe_pkg::WIDTH_16, FILL_ALL, 32'hffff, 32'h0, 16'h0,
                 32'hffff, 1'b0, 32'h0);
        // Double shifts: plain rule at 8 bits, second word at 16 bits, full dest.
        queue_op(xlsfe_pkg::CMD_DSHL, xlsfe_pkg::WIDTH_8, FILL_ALL, 32'h20, 32'h3,
                 16'hffff, 32'h0, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_DSHL, xlsfe_pkg::WIDTH_16, FILL_ALL, 32'h0, 32'h14,
                 16'h0800, 32'h5a5a, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_DSHL, xlsfe_pkg::WIDTH_16, FILL_ALL, 32'h0, 32'h20,
                 16'h0001, 32'h0, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_DSHR, xlsfe_pkg::WIDTH_16, FILL_ALL, 32'h8000_0000, 32'h20,
                 16'h0, 32'h0, 1'b0, 32'h0);
        queue_op(xlsfe_pkg::CMD_DSHR, WIDTH_32, FILL_SPARE_5, 32'hffff_ffff, 32'h0, 16'h0,
                 32'h0, 1'b1, 32'h0);

        // Random records; most carry the result that the operation would give.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            roll = $urandom_range(0, 39);
            if (roll == 0) op.command = xlsfe_pkg::CMD_NONE;
            else if (roll == 1) op.command = 4'($urandom_range(14, 15));
            else op.command = 4'($urandom_range(1, 13));
            op.width_code = $urandom_range(0, 15) == 0 ? WIDTH_SPARE
                                                      : 2'($urandom_range(0, 2));
            op.fill_mode = $urandom_range(0, 7) == 0 ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
            dv = corner_word();
            sv = $urandom_range(0, 9) == 0 ? dv : corner_word();
            op.second_dest = 16'($urandom);
            op.carry_in = 1'($urandom);
            op.old_flags = $urandom;
            bits = op.width_code == xlsfe_pkg::WIDTH_8 ? 8
                 : op.width_code == xlsfe_pkg::WIDTH_16 ? 16 : 32;
            msk = bits == 32 ? 32'hffff_ffff : (32'h1 << bits) - 1;

            // Shift counts mostly land in or just past the useful range.
            if (op.command >= xlsfe_pkg::CMD_SHL && op.command <= xlsfe_pkg::CMD_DSHR
                    && $urandom_range(0, 3) != 0) begin
                sv[7:0] = (op.command >= xlsfe_pkg::CMD_DSHL)
                        ? 8'($urandom_range(0, 34))
                        : 8'($urandom_range(0, bits + 2));
            end
            cnt = sv[7:0];
            op.dest_value = dv;
            op.source_value = sv;

            case (op.command)
                xlsfe_pkg::CMD_ADD:   op.result_value = dv + sv;
                xlsfe_pkg::CMD_ADC:   op.result_value = dv + sv + op.carry_in;
                xlsfe_pkg::CMD_SUB:   op.result_value = dv - sv;
                xlsfe_pkg::CMD_SBB:   op.result_value = dv - sv - op.carry_in;
                xlsfe_pkg::CMD_LOGIC: op.result_value = dv ^ sv;
                xlsfe_pkg::CMD_INC:   op.result_value = dv + 1;
                xlsfe_pkg::CMD_DEC:   op.result_value = dv - 1;
                xlsfe_pkg::CMD_NEG:   op.result_value = -dv;
                xlsfe_pkg::CMD_SHL:   op.result_value = dv << cnt;
                xlsfe_pkg::CMD_SHR:   op.result_value = (dv & msk) >> cnt;
                xlsfe_pkg::CMD_SAR: begin
                    sext = dv & msk;
                    if ((sext & ~(msk >> 1)) != 0) sext = sext | ~msk;
                    op.result_value = $signed(sext) >>> cnt;
                end
                default:   op.result_value = corner_word();
            endcase
            if ($urandom_range(0, 4) == 0) op.result_value = corner_word();
            pending_ops.push_back(op);
        end

        // Drain: every record accepted and every result checked.
        while (pending_ops.size() != 0 || expected_flags_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Input driver: holds a beat until accepted, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_flags_q.push_back(predict_flags(pending_ops.pop_front()));
            end
            if (!in_valid || !o_in_stall) begin
                if (in_gap_left > 0) begin
                    in_gap_left <= in_gap_left - 1;
                    in_valid <= 1'b0;
                end else if (pending_ops.size() != 0 && idling_on()
                             && $urandom_range(0, 3) == 0) begin
                    in_gap_left <= $urandom_range(0, 8);
                    in_valid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    drive_op <= pending_ops[0];
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result beat and drives random stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_flags_q.size() == 0) begin
                    log_mismatch("unexpected result", 32'h0, o_new_flags);
                end else begin
                    want_flags = expected_flags_q.pop_front();
                    if (o_new_flags !== want_flags) begin
                        log_mismatch("flags mismatch", want_flags, o_new_flags);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end else if (idling_on() && $urandom_range(0, 3) == 0) begin
                stall_left <= $urandom_range(0, 8);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

endmodule

// ===== files.f =====
hw/rtl/xlsfe_pkg.sv
hw/rtl/xlsfe_flag_calc.sv
hw/rtl/x86_lazy_status_flag_evaluator_unit.sv
tb/testbench.sv
